FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the RTL. Empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AST_IMPL(label, clk, rstn, ante, cons, msg)
`define AST_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/bnaf_pkg.sv
// ----------------------------------------------------------------------------
// bnaf_pkg
// Types and constants of the Boolean network attractor fitness block.
// ----------------------------------------------------------------------------
package bnaf_pkg;

    localparam int TBL_W     = 32;   // truth table bits per gene
    localparam int MAX_GENES = 5;    // tables carried by one input beat
    localparam int CFG_W     = 5;    // start and goal register width
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 51;   // fitness numerator and denominator
    localparam int LEN_W     = 6;    // reported cycle length

    localparam int S_TDATA_W = MAX_GENES * TBL_W;
    localparam int M_FIELD_W = 2 * PROD_W + 2 * LEN_W + 1;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_A  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_B  = 2'd3;

    // register reset values
    localparam logic [CFG_W-1:0] RST_START_A = 5'h10;
    localparam logic [CFG_W-1:0] RST_START_B = 5'h00;
    localparam logic [CFG_W-1:0] RST_GOAL_A  = 5'h15;
    localparam logic [CFG_W-1:0] RST_GOAL_B  = 5'h0a;

    // control of the shared multiply unit
    typedef struct packed {
        logic load;   // set accumulator to one
        logic step;   // accumulator times operand
    } mac_ctrl_t;

endpackage

FILE: hw/rtl/bnaf_net_step.sv
// ----------------------------------------------------------------------------
// bnaf_net_step
// One synchronous update of the Boolean network: gene g looks up its table
// at the state rotated left by g and drives state bit GENES-1-g.
// ----------------------------------------------------------------------------
module bnaf_net_step
    import bnaf_pkg::*;
#(
    parameter int GENES = 5
) (
    input  logic [TBL_W-1:0] tables [GENES],
    input  logic [GENES-1:0] cur_state,
    output logic [GENES-1:0] next_state
);

    logic [2*GENES-1:0] dbl;

    assign dbl = {cur_state, cur_state};

    always_comb begin
        logic [GENES-1:0] idx;
        next_state = '0;
        for (int g = 0; g < GENES; g++) begin
            idx = dbl[2*GENES-1-g -: GENES];
            next_state[GENES-1-g] = tables[g][5'(idx)];
        end
    end

endmodule

FILE: hw/rtl/bnaf_mac.sv
// ----------------------------------------------------------------------------
// bnaf_mac
// Shared multiply unit: a product register that is reset to one and then
// multiplied by one narrow operand per cycle in which step is set.
// ----------------------------------------------------------------------------
module bnaf_mac
    import bnaf_pkg::*;
#(
    parameter int OP_W = 6
) (
    input  logic              aclk,
    input  mac_ctrl_t         ctrl,
    input  logic [OP_W-1:0]   operand,
    output logic [PROD_W-1:0] acc
);

    logic [PROD_W-1:0]      acc_reg;
    logic [PROD_W+OP_W-1:0] prod;

    assign prod = acc_reg * operand;
    assign acc  = acc_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            acc_reg <= PROD_W'(1);
        end else if (ctrl.step) begin
            // partial products never exceed the final bound of 2^50
            acc_reg <= prod[PROD_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/boolean_network_attractor_fitness.sv
// ----------------------------------------------------------------------------
// boolean_network_attractor_fitness
// Scores one genome of GENES truth tables by the attractor cycles it reaches
// from two configured start states, as an exact unreduced fraction.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. Per item the network update unit runs
// 2^GENES warm-up steps and then one walk of the attractor cycle for each of
// the two contexts, one step a cycle, after which the shared multiplier
// forms the numerator and the denominator with one factor a cycle (GENES
// factors per context each). A finished result waits in the output
// register while the next item is taken. The user must write configuration
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module boolean_network_attractor_fitness
    import bnaf_pkg::*;
#(
    parameter int GENES = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // gene0_table .. gene4_table, 32 bits each
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // fitness_num, fitness_den, cycle_len_a,
                                            // cycle_len_b, fully_fit, zero pad
);

    localparam int J_W = $clog2(GENES);
    localparam logic [GENES:0]   NSTATES = (GENES+1)'(1) << GENES;
    localparam logic [J_W-1:0]   J_LAST  = J_W'(GENES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WARM,
        S_CYCLE,
        S_MUL_NUM,
        S_SWAP,
        S_MUL_DEN,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic              ctx_reg;
    logic [GENES-1:0]  net_reg;
    logic [GENES-1:0]  entry_reg;
    logic [GENES-1:0]  step_reg;
    logic [GENES:0]    cnt_reg [2][GENES];
    logic [GENES:0]    len_reg [2];
    logic [J_W-1:0]    j_reg;
    logic [TBL_W-1:0]  table_reg [GENES];
    logic [PROD_W-1:0] num_reg;

    logic [CFG_W-1:0]  start_a_reg, start_b_reg, goal_a_reg, goal_b_reg;

    logic              m_tvalid_reg;
    logic [PROD_W-1:0] out_num_reg, out_den_reg;
    logic [LEN_W-1:0]  out_len_a_reg, out_len_b_reg;
    logic              out_fit_reg;

    logic              accept;
    logic              out_free;
    logic [GENES-1:0]  net_next;
    logic [GENES-1:0]  goal;
    logic [GENES-1:0]  match;
    logic [GENES:0]    len_inc;
    logic              walk_done;
    logic              mul_last;
    logic [GENES:0]    mul_op;
    mac_ctrl_t         mac_ctrl;
    logic [PROD_W-1:0] acc;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    bnaf_net_step #(.GENES(GENES)) u_step (
        .tables     (table_reg),
        .cur_state  (net_reg),
        .next_state (net_next)
    );

    assign goal      = ctx_reg ? GENES'(goal_b_reg) : GENES'(goal_a_reg);
    assign match     = ~(net_reg ^ goal);
    assign len_inc   = len_reg[ctx_reg] + 1'b1;
    assign walk_done = (net_next == entry_reg) || (len_inc == NSTATES);
    assign mul_last  = ctx_reg && (j_reg == J_LAST);
    assign mul_op    = (state_reg == S_MUL_DEN) ? len_reg[ctx_reg] : cnt_reg[ctx_reg][j_reg];

    assign mac_ctrl.load = accept || (state_reg == S_SWAP);
    assign mac_ctrl.step = (state_reg == S_MUL_NUM) || (state_reg == S_MUL_DEN);

    bnaf_mac #(.OP_W(GENES + 1)) u_mac (
        .aclk    (aclk),
        .ctrl    (mac_ctrl),
        .operand (mul_op),
        .acc     (acc)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (accept) state_next = S_WARM;
            S_WARM:    if (&step_reg) state_next = S_CYCLE;
            S_CYCLE:   if (walk_done) state_next = ctx_reg ? S_MUL_NUM : S_WARM;
            S_MUL_NUM: if (mul_last) state_next = S_SWAP;
            S_SWAP:    state_next = S_MUL_DEN;
            S_MUL_DEN: if (mul_last) state_next = S_FINISH;
            S_FINISH:  if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ctx_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            start_a_reg  <= RST_START_A;
            start_b_reg  <= RST_START_B;
            goal_a_reg   <= RST_GOAL_A;
            goal_b_reg   <= RST_GOAL_B;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (cfg_index)
                    CFG_START_A: start_a_reg <= cfg_wdata;
                    CFG_START_B: start_b_reg <= cfg_wdata;
                    CFG_GOAL_A:  goal_a_reg  <= cfg_wdata;
                    CFG_GOAL_B:  goal_b_reg  <= cfg_wdata;
                    default: ;
                endcase
            end

            if ((state_reg == S_FINISH) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        for (int g = 0; g < GENES; g++) begin
                            table_reg[g]  <= s_tdata[g*TBL_W +: TBL_W];
                            cnt_reg[0][g] <= '0;
                            cnt_reg[1][g] <= '0;
                        end
                        len_reg[0] <= '0;
                        len_reg[1] <= '0;
                        net_reg    <= GENES'(start_a_reg);
                        ctx_reg    <= 1'b0;
                        step_reg   <= '0;
                        j_reg      <= '0;
                    end
                end
                S_WARM: begin
                    // after 2^GENES steps the state is on its cycle
                    net_reg  <= net_next;
                    step_reg <= step_reg + 1'b1;
                    if (&step_reg) begin
                        entry_reg <= net_next;
                    end
                end
                S_CYCLE: begin
                    for (int g = 0; g < GENES; g++) begin
                        cnt_reg[ctx_reg][g] <= cnt_reg[ctx_reg][g] + (GENES+1)'(match[g]);
                    end
                    len_reg[ctx_reg] <= len_inc;
                    if (walk_done) begin
                        // move to the second context, or hand off to the multiplier
                        ctx_reg  <= !ctx_reg;
                        net_reg  <= GENES'(start_b_reg);
                        step_reg <= '0;
                        j_reg    <= '0;
                    end else begin
                        net_reg  <= net_next;
                    end
                end
                S_MUL_NUM, S_MUL_DEN: begin
                    if (j_reg == J_LAST) begin
                        j_reg   <= '0;
                        ctx_reg <= !ctx_reg;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_SWAP: begin
                    num_reg <= acc;
                end
                S_FINISH: begin
                    if (out_free) begin
                        out_num_reg   <= num_reg;
                        out_den_reg   <= acc;
                        out_len_a_reg <= LEN_W'(len_reg[0]);
                        out_len_b_reg <= LEN_W'(len_reg[1]);
                        out_fit_reg   <= (num_reg == acc);
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {
        (M_TDATA_W - M_FIELD_W)'(0),
        out_fit_reg,
        out_len_b_reg,
        out_len_a_reg,
        out_den_reg,
        out_num_reg
    };

    `AST_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_tready, "input taken while busy")
    `AST_IMPL(a_len_nonzero, aclk, aresetn, m_tvalid_reg,
              (out_len_a_reg != '0) && (out_len_b_reg != '0) && (out_den_reg != '0),
              "zero cycle length in result")
    `AST_IMPL(a_fit_flag, aclk, aresetn, m_tvalid_reg,
              out_fit_reg == (out_num_reg == out_den_reg), "fully_fit flag mismatch")

endmodule

FILE: tb/boolean_network_attractor_fitness_tb.sv
// ----------------------------------------------------------------------------
// boolean_network_attractor_fitness_tb
// Streams genomes into the attractor fitness scorer and checks each beat
// against a typed score or a behavioral walker kept in the bench. A directed
// table covers fixed points, two-state oscillations, rotation and counter networks under
// extreme start and goal settings. Random genomes follow: raw tables,
// permutations and networks built around a chosen cycle length.
// ----------------------------------------------------------------------------
module boolean_network_attractor_fitness_tb;
    import bnaf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NG      = 5;
    localparam int NSTATES = 1 << NG;

    typedef logic [MAX_GENES-1:0][TBL_W-1:0] genome_t;   // gene0 in the low bits
    typedef logic [NG-1:0] state_map_t [NSTATES];

    typedef struct packed {
        logic [CFG_W-1:0] start_a;
        logic [CFG_W-1:0] start_b;
        logic [CFG_W-1:0] goal_a;
        logic [CFG_W-1:0] goal_b;
    } net_cfg_t;

    // last member sits in the low bits, matching the m_tdata layout
    typedef struct packed {
        logic              fit;
        logic [LEN_W-1:0]  len_b;
        logic [LEN_W-1:0]  len_a;
        logic [PROD_W-1:0] den;
        logic [PROD_W-1:0] num;
    } fitness_t;

    typedef struct packed {
        net_cfg_t cfg;
        genome_t  genome;
        logic     has_want;
        fitness_t want;
    } directed_row_t;

    localparam net_cfg_t RESET_CFG = {RST_START_A, RST_START_B, RST_GOAL_A, RST_GOAL_B};

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_START_A;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    boolean_network_attractor_fitness #(
        .GENES(NG)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    net_cfg_t        active_cfg = RESET_CFG;
    fitness_t        expected_scores[$];
    directed_row_t   directed_rows[$];
    int              snd_idle_pct = 0;
    int              rcv_idle_pct = 0;
    int              genomes_sent = 0;
    int              scores_checked = 0;
    int              mismatches = 0;
    int              fit_count = 0;
    int              cfg_switches = 0;
    int              longest_cycle = 0;
    logic [NSTATES:0] lens_seen = '0;
    fitness_t        got_score;
    fitness_t        want_score;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("boolean_network_attractor_fitness verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // network walker
    // ------------------------------------------------------------------------
    function automatic logic [NG-1:0] rot_state(logic [NG-1:0] s, int gi);
        logic [NG-1:0] lo;
        lo = s << gi;
        return lo | (s >> (NG - gi));
    endfunction

    function automatic logic [NG-1:0] step_state(genome_t g, logic [NG-1:0] s);
        logic [NG-1:0] nxt;
        nxt = '0;
        for (int gi = 0; gi < NG; gi++)
            nxt[NG-1-gi] = g[gi][rot_state(s, gi)];
        return nxt;
    endfunction

    function automatic void walk_attractor(genome_t g, logic [NG-1:0] start,
                                           logic [NG-1:0] goal,
                                           inout longint unsigned num,
                                           inout longint unsigned den,
                                           output logic [LEN_W-1:0] len);
        logic [NG-1:0] s;
        logic [NG-1:0] entry;
        logic [NG-1:0] match;
        int unsigned   hits [NG];
        int unsigned   n;
        s = start;
        repeat (NSTATES) s = step_state(g, s);
        entry = s;
        foreach (hits[j]) hits[j] = 0;
        n = 0;
        do begin
            match = ~(s ^ goal);
            for (int j = 0; j < NG; j++)
                hits[j] += match[j];
            n++;
            s = step_state(g, s);
        end while (s != entry && n < NSTATES);
        for (int j = 0; j < NG; j++) begin
            num *= hits[j];
            den *= n;
        end
        len = n[LEN_W-1:0];
    endfunction

    function automatic fitness_t score_genome(genome_t g, net_cfg_t c);
        longint unsigned num;
        longint unsigned den;
        fitness_t        r;
        num = 1;
        den = 1;
        walk_attractor(g, c.start_a, c.goal_a, num, den, r.len_a);
        walk_attractor(g, c.start_b, c.goal_b, num, den, r.len_b);
        r.num = num[PROD_W-1:0];
        r.den = den[PROD_W-1:0];
        r.fit = (num == den);
        return r;
    endfunction

    function automatic fitness_t typed_score(longint unsigned num, longint unsigned den,
                                             int la, int lb, bit f);
        fitness_t r;
        r.num   = num[PROD_W-1:0];
        r.den   = den[PROD_W-1:0];
        r.len_a = la[LEN_W-1:0];
        r.len_b = lb[LEN_W-1:0];
        r.fit   = f;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // genome construction from a next-state map
    // ------------------------------------------------------------------------
    function automatic genome_t genome_from_map(state_map_t m);
        genome_t g;
        g = '0;
        for (int s = 0; s < NSTATES; s++)
            for (int gi = 0; gi < NG; gi++)
                g[gi][rot_state(s[NG-1:0], gi)] = m[s][NG-1-gi];
        return g;
    endfunction

    function automatic state_map_t shuffled_states();
        state_map_t    m;
        logic [NG-1:0] tmp;
        int            j;
        for (int i = 0; i < NSTATES; i++) m[i] = i[NG-1:0];
        for (int i = NSTATES - 1; i > 0; i--) begin
            j    = $urandom_range(0, i);
            tmp  = m[i];
            m[i] = m[j];
            m[j] = tmp;
        end
        return m;
    endfunction

    // one cycle of the given length; every other state drains into it
    function automatic genome_t attractor_genome(int cyc);
        state_map_t order;
        state_map_t m;
        order = shuffled_states();
        for (int i = 0; i < NSTATES; i++) begin
            if (i < cyc)
                m[order[i]] = order[(i + 1) % cyc];
            else
                m[order[i]] = order[$urandom_range(0, i - 1)];
        end
        return genome_from_map(m);
    endfunction

    function automatic genome_t counter_genome();
        state_map_t m;
        for (int s = 0; s < NSTATES; s++) m[s] = NG'(s + 1);
        return genome_from_map(m);
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    always @(posedge aclk)
        m_tready <= (rcv_idle_pct == 0) || ($urandom_range(0, 99) >= rcv_idle_pct);

    task automatic load_config(net_cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START_A;
        cfg_wdata <= c.start_a;
        @(posedge aclk);
        cfg_index <= CFG_START_B;
        cfg_wdata <= c.start_b;
        @(posedge aclk);
        cfg_index <= CFG_GOAL_A;
        cfg_wdata <= c.goal_a;
        @(posedge aclk);
        cfg_index <= CFG_GOAL_B;
        cfg_wdata <= c.goal_b;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        active_cfg  = c;
        cfg_switches++;
        @(posedge aclk);
    endtask

    task automatic drain_scores();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_scores.size() != 0) @(posedge aclk);
        // let the result register settle before touching configuration
        repeat (8) @(posedge aclk);
    endtask

    task automatic send_genome(genome_t g, logic use_typed, fitness_t typed);
        fitness_t want;
        if (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 150)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= g;
        do @(posedge aclk); while (!s_tready);
        want = use_typed ? typed : score_genome(g, active_cfg);
        expected_scores.insert(expected_scores.size(), want);
        genomes_sent++;
    endtask

    task automatic add_row(net_cfg_t c, genome_t g, logic has_want, fitness_t w);
        directed_row_t row;
        row.cfg      = c;
        row.genome   = g;
        row.has_want = has_want;
        row.want     = w;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // ------------------------------------------------------------------------
    // score checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got_score = fitness_t'(m_tdata[M_FIELD_W-1:0]);
            if (expected_scores.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected score beat: num=%0d den=%0d len_a=%0d len_b=%0d fit=%0b",
                             got_score.num, got_score.den, got_score.len_a,
                             got_score.len_b, got_score.fit);
            end else begin
                want_score = expected_scores.pop_front();
                scores_checked++;
                if (want_score.len_a <= NSTATES) lens_seen[want_score.len_a] = 1'b1;
                if (want_score.len_b <= NSTATES) lens_seen[want_score.len_b] = 1'b1;
                if (want_score.len_a > longest_cycle) longest_cycle = want_score.len_a;
                if (want_score.len_b > longest_cycle) longest_cycle = want_score.len_b;
                if (want_score.fit) fit_count++;
                if (got_score.num !== want_score.num || got_score.den !== want_score.den ||
                    got_score.len_a !== want_score.len_a ||
                    got_score.len_b !== want_score.len_b ||
                    got_score.fit !== want_score.fit) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("score %0d mismatch at %0t", scores_checked, $realtime);
                        $display("  expected num=%0d den=%0d len_a=%0d len_b=%0d fit=%0b",
                                 want_score.num, want_score.den, want_score.len_a,
                                 want_score.len_b, want_score.fit);
                        $display("  actual   num=%0d den=%0d len_a=%0d len_b=%0d fit=%0b",
                                 got_score.num, got_score.den, got_score.len_a,
                                 got_score.len_b, got_score.fit);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        genome_t  zero_g;
        genome_t  ones_g;
        genome_t  not_g;
        genome_t  ident_g;
        genome_t  rot_g;
        genome_t  count_g;
        genome_t  g;
        net_cfg_t all_lo;
        net_cfg_t all_hi;
        net_cfg_t crossed;
        net_cfg_t alt;
        net_cfg_t c;
        fitness_t none;
        int       pick;
        int       cyc;

        zero_g  = '0;
        ones_g  = '1;
        not_g   = {MAX_GENES{32'h0000ffff}};   // next = ~s, every start lands on an attractor of two states
        ident_g = {MAX_GENES{32'hffff0000}};   // next = s, every state a fixed point
        rot_g   = {MAX_GENES{32'hff00ff00}};   // next = s rotated left by one
        count_g = counter_genome();
        all_lo  = '0;
        all_hi  = '1;
        crossed = {5'h1f, 5'h00, 5'h00, 5'h1f};
        alt     = {5'h0a, 5'h15, 5'h0a, 5'h15};
        none    = '0;

        add_row(RESET_CFG, zero_g,  1'b1, typed_score(0, 1, 1, 1, 0));
        add_row(RESET_CFG, ones_g,  1'b1, typed_score(0, 1, 1, 1, 0));
        add_row(RESET_CFG, not_g,   1'b1, typed_score(1, 1024, 2, 2, 0));
        add_row(RESET_CFG, ident_g, 1'b1, typed_score(0, 1, 1, 1, 0));
        add_row(RESET_CFG, rot_g,   1'b0, none);
        add_row(RESET_CFG, count_g, 1'b0, none);
        add_row(RESET_CFG, {32'hf0f0f0f0, 32'h33333333, 32'hcccccccc,
                            32'h55555555, 32'haaaaaaaa}, 1'b0, none);
        add_row(RESET_CFG, {32'hffffffff, 32'h00000000, 32'h80000001,
                            32'h00000001, 32'h80000000}, 1'b0, none);
        add_row(RESET_CFG, {32'h0000ffff, 32'h00010000, 32'h7fffffff,
                            32'hfffffffe, 32'h7ffffffe}, 1'b0, none);
        add_row(all_lo, zero_g,  1'b1, typed_score(1, 1, 1, 1, 1));
        add_row(all_lo, ident_g, 1'b1, typed_score(1, 1, 1, 1, 1));
        add_row(all_lo, not_g,   1'b1, typed_score(1, 1024, 2, 2, 0));
        add_row(all_lo, count_g, 1'b0, none);
        add_row(all_hi, ones_g,  1'b1, typed_score(1, 1, 1, 1, 1));
        add_row(all_hi, ident_g, 1'b1, typed_score(1, 1, 1, 1, 1));
        add_row(all_hi, zero_g,  1'b1, typed_score(0, 1, 1, 1, 0));
        add_row(all_hi, rot_g,   1'b0, none);
        add_row(crossed, not_g,   1'b1, typed_score(1, 1024, 2, 2, 0));
        add_row(crossed, ident_g, 1'b1, typed_score(0, 1, 1, 1, 0));
        add_row(crossed, count_g, 1'b0, none);
        add_row(crossed, attractor_genome(NSTATES), 1'b0, none);
        add_row(alt, rot_g,   1'b0, none);
        add_row(alt, ident_g, 1'b1, typed_score(1, 1, 1, 1, 1));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        snd_idle_pct = 31;
        rcv_idle_pct = 78;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg != active_cfg) begin
                drain_scores();
                load_config(directed_rows[i].cfg);
            end
            send_genome(directed_rows[i].genome, directed_rows[i].has_want,
                        directed_rows[i].want);
        end

        for (int seg = 0; seg < 6; seg++) begin
            drain_scores();
            snd_idle_pct = (seg < 2) ? 31 : (seg < 4) ? 78 : 0;
            rcv_idle_pct = (seg < 2) ? 78 : (seg < 4) ? 31 : 0;
            c = {5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31))};
            load_config(c);
            repeat (215) begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    for (int gi = 0; gi < MAX_GENES; gi++) g[gi] = $urandom();
                end else if (pick < 50) begin
                    g = genome_from_map(shuffled_states());
                end else begin
                    cyc = ($urandom_range(0, 9) == 0) ? NSTATES : $urandom_range(1, NSTATES);
                    g   = attractor_genome(cyc);
                end
                send_genome(g, 1'b0, none);
                // hold off now and then until the scorer has emptied
                if ($urandom_range(0, 99) == 0)
                    drain_scores();
            end
        end

        drain_scores();
        repeat (140) @(posedge aclk);

        $display("%0d genomes scored under %0d register settings, %0d scores checked",
                 genomes_sent, cfg_switches + 1, scores_checked);
        $display("%0d distinct cycle lengths seen (longest %0d), %0d fully fit, %0d mismatches",
                 $countones(lens_seen), longest_cycle, fit_count, mismatches);
        if (mismatches == 0 && expected_scores.size() == 0) begin
            $display("boolean_network_attractor_fitness verification clean");
        end else begin
            $display("boolean_network_attractor_fitness verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/bnaf_pkg.sv
hw/rtl/bnaf_net_step.sv
hw/rtl/bnaf_mac.sv
hw/rtl/boolean_network_attractor_fitness.sv
tb/boolean_network_attractor_fitness_tb.sv
